@@ hw/rtl/lmrsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrsd_pkg
// shared constants and types of the led matrix row scan driver
// ----------------------------------------------------------------------------
`default_nettype none

package lmrsd_pkg;

  // default panel geometry
  localparam int COLUMNS_DEFAULT   = 32;
  localparam int ROW_PAIRS_DEFAULT = 8;

  // fixed item field widths
  localparam int COL_W    = 5;
  localparam int ROW_W    = 4;
  localparam int COLOUR_W = 3;
  localparam int HOLD_W   = 16;
  localparam int ADDR_PIN_W = 3;

  localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd1000;

  // item kinds on tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // scan phases
  localparam logic [2:0] PH_BLANK = 3'd0;
  localparam logic [2:0] PH_LOW   = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_LATCH = 3'd3;
  localparam logic [2:0] PH_SHOW  = 3'd4;

  // panel control pins as they stand after an item
  typedef struct packed {
    logic [ADDR_PIN_W-1:0] row_address;
    logic                  output_blank;
    logic                  latch_strobe;
    logic                  shift_clock;
  } pins_t;

endpackage

`default_nettype wire

@@ hw/rtl/lmrsd_ram.sv @@
// ----------------------------------------------------------------------------
// lmrsd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lmrsd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lmrsd_seq.sv @@
// ----------------------------------------------------------------------------
// lmrsd_seq
// scan sequencer: phase, row, column and hold counters, control pins
// ----------------------------------------------------------------------------
`default_nettype none

module lmrsd_seq #(
  parameter int COLUMNS   = lmrsd_pkg::COLUMNS_DEFAULT,
  parameter int ROW_PAIRS = lmrsd_pkg::ROW_PAIRS_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   tick,
  input  wire logic [lmrsd_pkg::HOLD_W-1:0]           hold_ticks,
  output lmrsd_pkg::pins_t                            pins_next,
  output logic                                        load,
  output logic [$clog2(COLUMNS*ROW_PAIRS)-1:0]        rd_addr
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROW_PAIRS);
  localparam int AW = $clog2(COLUMNS*ROW_PAIRS);

  logic [2:0]                   phase, phase_next;
  logic [RW-1:0]                scan_row, scan_row_next;
  logic [CW-1:0]                scan_column, scan_column_next;
  logic [lmrsd_pkg::HOLD_W-1:0] hold_count, hold_count_next;
  lmrsd_pkg::pins_t             pins, pins_step;

  assign rd_addr = AW'(scan_row) * AW'(COLUMNS) + AW'(scan_column);

  always_comb begin
    phase_next       = phase;
    scan_row_next    = scan_row;
    scan_column_next = scan_column;
    hold_count_next  = hold_count;
    pins_step        = pins;
    load             = 1'b0;
    case (phase)
      lmrsd_pkg::PH_BLANK: begin
        pins_step.output_blank = 1'b1;
        pins_step.row_address  = lmrsd_pkg::ADDR_PIN_W'(scan_row);
        pins_step.shift_clock  = 1'b0;
        pins_step.latch_strobe = 1'b0;
        scan_column_next       = '0;
        phase_next             = lmrsd_pkg::PH_LOW;
      end
      lmrsd_pkg::PH_LOW: begin
        load                  = 1'b1;
        pins_step.shift_clock = 1'b0;
        phase_next            = lmrsd_pkg::PH_HIGH;
      end
      lmrsd_pkg::PH_HIGH: begin
        pins_step.shift_clock = 1'b1;
        if (scan_column == CW'(COLUMNS - 1)) begin
          scan_column_next = '0;
          phase_next       = lmrsd_pkg::PH_LATCH;
        end else begin
          scan_column_next = scan_column + 1'b1;
          phase_next       = lmrsd_pkg::PH_LOW;
        end
      end
      lmrsd_pkg::PH_LATCH: begin
        pins_step.shift_clock  = 1'b0;
        pins_step.latch_strobe = 1'b1;
        hold_count_next        = '0;
        phase_next             = lmrsd_pkg::PH_SHOW;
      end
      default: begin
        // display phase, also taken by unused codes
        pins_step.latch_strobe = 1'b0;
        pins_step.output_blank = 1'b0;
        if (hold_count >= hold_ticks) begin
          hold_count_next = '0;
          scan_row_next   = (scan_row == RW'(ROW_PAIRS - 1)) ? '0 : scan_row + 1'b1;
          phase_next      = lmrsd_pkg::PH_BLANK;
        end else begin
          hold_count_next = hold_count + 1'b1;
        end
      end
    endcase
  end

  assign pins_next = tick ? pins_step : pins;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lmrsd_pkg::PH_BLANK;
      scan_row    <= '0;
      scan_column <= '0;
      hold_count  <= '0;
      pins        <= '0;
    end else if (tick) begin
      phase       <= phase_next;
      scan_row    <= scan_row_next;
      scan_column <= scan_column_next;
      hold_count  <= hold_count_next;
      pins        <= pins_step;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/led_matrix_row_scan_driver.sv @@
// ----------------------------------------------------------------------------
// led_matrix_row_scan_driver
// row scan driver for a two-half rgb led panel fed from a frame store
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake                       | contents
//   ----------+-----------+---------------------------------+---------------------------
//   s_axis    | in        | s_axis_tvalid / s_axis_tready   | scan tick or pixel write
//   m_axis    | out       | m_axis_tvalid / m_axis_tready   | panel pin state per item
//   cfg       | in        | cfg_valid / cfg_ready           | hold_ticks register
//
// one item per cycle sustained while m_axis takes results; every item gives one result,
// registered in stage 1 (frame store read) and then in the output register
// the frame store is two rams, upper and lower half rows, so one clock-low tick
// reads the top and bottom pixel in the same cycle while a write uses one half
// after reset a clearing pass writes zero to COLUMNS*ROW_PAIRS entries of both
// halves, one entry per cycle; s_axis_tready stays low until it ends
// a stall on m_axis holds the staged item and then s_axis_tready; cfg is always ready
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_row_scan_driver #(
  parameter int COLUMNS   = lmrsd_pkg::COLUMNS_DEFAULT,
  parameter int ROW_PAIRS = lmrsd_pkg::ROW_PAIRS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] pixel_column, [8:5] pixel_row, [11:9] pixel_colour, [15:12] zero
  input  wire logic [15:0] s_axis_tdata,
  // [0] opcode
  input  wire logic [0:0]  s_axis_tuser,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] red_top, [1] green_top, [2] blue_top, [3] red_bottom, [4] green_bottom,
  // [5] blue_bottom, [6] shift_clock, [7] latch_strobe, [8] output_blank,
  // [11:9] row_address, [15:12] zero
  output logic [15:0]      m_axis_tdata,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int HALF = COLUMNS * ROW_PAIRS;   // entries per half of the store
  localparam int AW   = $clog2(HALF);
  localparam int RW   = $clog2(ROW_PAIRS);
  localparam int CLW  = lmrsd_pkg::COLOUR_W;

  // configuration register
  logic [lmrsd_pkg::HOLD_W-1:0] hold_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= lmrsd_pkg::HOLD_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_ticks <= cfg_data;
    end
  end

  // input fields
  logic                          in_accept;
  logic [lmrsd_pkg::COL_W-1:0]   pixel_column;
  logic [lmrsd_pkg::ROW_W-1:0]   pixel_row;
  logic [CLW-1:0]                pixel_colour;

  assign pixel_column = s_axis_tdata[4:0];
  assign pixel_row    = s_axis_tdata[8:5];
  assign pixel_colour = s_axis_tdata[11:9];
  assign in_accept    = s_axis_tvalid && s_axis_tready;

  logic is_write, is_tick;
  assign is_write = in_accept && (s_axis_tuser[0] == lmrsd_pkg::OP_WRITE);
  assign is_tick  = in_accept && (s_axis_tuser[0] == lmrsd_pkg::OP_TICK);

  // clearing pass after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(HALF - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // pixel write decode: out-of-range writes are dropped
  logic          col_ok, row_ok, wr_bottom, wr_ok;
  logic [RW-1:0] wr_half_row;
  logic [AW-1:0] wr_addr;

  assign col_ok      = int'(pixel_column) < COLUMNS;
  assign row_ok      = int'(pixel_row) < 2 * ROW_PAIRS;
  assign wr_bottom   = int'(pixel_row) >= ROW_PAIRS;
  assign wr_ok       = is_write && col_ok && row_ok;
  assign wr_half_row = wr_bottom ? RW'(int'(pixel_row) - ROW_PAIRS) : RW'(pixel_row);
  assign wr_addr     = AW'(wr_half_row) * AW'(COLUMNS) + AW'(pixel_column);

  // scan sequencer
  lmrsd_pkg::pins_t pins_next;
  logic             load;
  logic [AW-1:0]    rd_addr;

  lmrsd_seq #(
    .COLUMNS   (COLUMNS),
    .ROW_PAIRS (ROW_PAIRS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick       (is_tick),
    .hold_ticks (hold_ticks),
    .pins_next  (pins_next),
    .load       (load),
    .rd_addr    (rd_addr)
  );

  // frame store halves
  logic           top_we, bot_we, rd_en;
  logic [AW-1:0]  ram_waddr;
  logic [CLW-1:0] ram_wdata, top_rd, bot_rd;

  assign top_we    = clearing || (wr_ok && !wr_bottom);
  assign bot_we    = clearing || (wr_ok && wr_bottom);
  assign ram_waddr = clearing ? clr_addr : wr_addr;
  assign ram_wdata = clearing ? '0 : pixel_colour;
  assign rd_en     = is_tick && load;

  lmrsd_ram #(
    .WIDTH (CLW),
    .DEPTH (HALF)
  ) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (top_rd)
  );

  lmrsd_ram #(
    .WIDTH (CLW),
    .DEPTH (HALF)
  ) u_bot_ram (
    .clk   (clk),
    .we    (bot_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (bot_rd)
  );

  // stage 1: waits for the ram read; holds pins and whether colours reload
  logic             s1_valid, s1_load, s1_go;
  lmrsd_pkg::pins_t s1_pins;

  // colour pins hold their last loaded value between column phases
  logic [CLW-1:0] top_colour, bottom_colour;
  logic [CLW-1:0] top_item, bottom_item;

  // output register
  logic        out_valid;
  logic [15:0] out_data;

  assign s1_go         = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || s1_go);

  assign top_item    = s1_load ? top_rd : top_colour;
  assign bottom_item = s1_load ? bot_rd : bottom_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pins <= pins_next;
      s1_load <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_colour    <= '0;
      bottom_colour <= '0;
    end else if (s1_go && s1_load) begin
      top_colour    <= top_rd;
      bottom_colour <= bot_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= {4'b0000, s1_pins.row_address, s1_pins.output_blank,
                   s1_pins.latch_strobe, s1_pins.shift_clock, bottom_item, top_item};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the led matrix row scan driver: pixel writes and
// scan ticks go in on s_axis, every pin state item coming back on m_axis is
// compared field by field against a fixed expectation or a cycle-free model of the panel scan
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import lmrsd_pkg::*;

  localparam int COLS      = COLUMNS_DEFAULT;
  localparam int ROW_PAIRS = ROW_PAIRS_DEFAULT;
  localparam int IMAGE_SZ  = COLS * 2 * ROW_PAIRS;

  // pin state in the bit order of m_axis_tdata[11:0]
  typedef struct packed {
    pins_t               ctrl;
    logic [COLOUR_W-1:0] bottom;
    logic [COLOUR_W-1:0] top;
  } panel_word_t;

  typedef struct {
    logic                op;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [COLOUR_W-1:0] colour;
    bit                  typed;
    panel_word_t         want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // panel model state
  logic [COLOUR_W-1:0] panel_image [IMAGE_SZ];
  int                  scan_row;
  int                  scan_col;
  logic [2:0]          scan_phase;
  int                  dwell;
  int                  hold_setting;
  panel_word_t         pins;

  panel_word_t pending_pins[$];
  stim_row_t   directed_rows[$];
  int          fail_count;
  int          ticks_sent;
  int          writes_sent;
  int          hold_writes;
  bit          calm;

  led_matrix_row_scan_driver dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic panel_word_t pins_of(input int top, input int bottom,
                                          input int sclk, input int latch,
                                          input int blank, input int addr);
    panel_word_t w;
    w.top                   = top[COLOUR_W-1:0];
    w.bottom                = bottom[COLOUR_W-1:0];
    w.ctrl.shift_clock      = sclk[0];
    w.ctrl.latch_strobe     = latch[0];
    w.ctrl.output_blank     = blank[0];
    w.ctrl.row_address      = addr[ADDR_PIN_W-1:0];
    return w;
  endfunction

  // advances the panel model by one item and returns the pins it leaves
  function automatic panel_word_t step_panel(input logic op, input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] row,
                                             input logic [COLOUR_W-1:0] colour);
    if (op == OP_WRITE) begin
      if (int'(col) < COLS && int'(row) < 2 * ROW_PAIRS)
        panel_image[int'(row) * COLS + int'(col)] = colour;
    end else begin
      case (scan_phase)
        PH_BLANK: begin
          pins.ctrl.output_blank = 1'b1;
          pins.ctrl.row_address  = scan_row[2:0];
          pins.ctrl.shift_clock  = 1'b0;
          pins.ctrl.latch_strobe = 1'b0;
          scan_col               = 0;
          scan_phase             = PH_LOW;
        end
        PH_LOW: begin
          pins.top               = panel_image[scan_row * COLS + scan_col];
          pins.bottom            = panel_image[(scan_row + ROW_PAIRS) * COLS + scan_col];
          pins.ctrl.shift_clock  = 1'b0;
          scan_phase             = PH_HIGH;
        end
        PH_HIGH: begin
          pins.ctrl.shift_clock = 1'b1;
          scan_col++;
          if (scan_col >= COLS) begin
            scan_col   = 0;
            scan_phase = PH_LATCH;
          end else begin
            scan_phase = PH_LOW;
          end
        end
        PH_LATCH: begin
          pins.ctrl.shift_clock  = 1'b0;
          pins.ctrl.latch_strobe = 1'b1;
          dwell                  = 0;
          scan_phase             = PH_SHOW;
        end
        default: begin
          pins.ctrl.latch_strobe = 1'b0;
          pins.ctrl.output_blank = 1'b0;
          // a lowered hold ends the display at once
          if (dwell >= hold_setting) begin
            dwell    = 0;
            scan_row = (scan_row + 1 >= ROW_PAIRS) ? 0 : scan_row + 1;
            scan_phase = PH_BLANK;
          end else begin
            dwell++;
          end
        end
      endcase
    end
    return pins;
  endfunction

  function automatic stim_row_t make_row(input logic op, input int col, input int row,
                                         input int colour, input bit typed,
                                         input panel_word_t want);
    stim_row_t r;
    r.op     = op;
    r.col    = col[COL_W-1:0];
    r.row    = row[ROW_W-1:0];
    r.colour = colour[COLOUR_W-1:0];
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  // presents one item, waits for the handshake, then records what should come back
  task automatic send_item(input logic op, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic [COLOUR_W-1:0] colour,
                           input bit typed, input panel_word_t want);
    panel_word_t predicted;
    while (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, colour, row, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = step_panel(op, col, row, colour);
    pending_pins.push_back(typed ? want : predicted);
    if (op == OP_WRITE) writes_sent++;
    else ticks_sent++;
  endtask

  task automatic run_random(input int count, input int tick_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_WRITE;
      send_item(op, COL_W'($urandom_range(COLS - 1)), ROW_W'($urandom_range(15)),
                COLOUR_W'($urandom_range(7)), 1'b0, '0);
    end
  endtask

  // every item gives a result, so an empty queue means the block is idle
  task automatic drain_items();
    s_axis_tvalid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  task automatic set_hold(input logic [HOLD_W-1:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    hold_setting = int'(ticks);
    hold_writes++;
  endtask

  task automatic check_pin(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result side stalls at random except in the calm stretch
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else     m_axis_tready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin : watch_results
    panel_word_t seen;
    panel_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[11:0];
      if (pending_pins.size() == 0) begin
        $error("pin state item with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_pins.pop_front();
        check_pin("red_top",      int'(want.top[0]),    int'(seen.top[0]));
        check_pin("green_top",    int'(want.top[1]),    int'(seen.top[1]));
        check_pin("blue_top",     int'(want.top[2]),    int'(seen.top[2]));
        check_pin("red_bottom",   int'(want.bottom[0]), int'(seen.bottom[0]));
        check_pin("green_bottom", int'(want.bottom[1]), int'(seen.bottom[1]));
        check_pin("blue_bottom",  int'(want.bottom[2]), int'(seen.bottom[2]));
        check_pin("shift_clock",  int'(want.ctrl.shift_clock),
                  int'(seen.ctrl.shift_clock));
        check_pin("latch_strobe", int'(want.ctrl.latch_strobe),
                  int'(seen.ctrl.latch_strobe));
        check_pin("output_blank", int'(want.ctrl.output_blank),
                  int'(seen.ctrl.output_blank));
        check_pin("row_address",  int'(want.ctrl.row_address),
                  int'(seen.ctrl.row_address));
      end
    end
  end

  initial begin
    #400000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    foreach (panel_image[i]) panel_image[i] = '0;
    scan_row     = 0;
    scan_col     = 0;
    scan_phase   = PH_BLANK;
    dwell        = 0;
    hold_setting = int'(HOLD_TICKS_RESET);
    pins         = '0;
    fail_count   = 0;
    ticks_sent   = 0;
    writes_sent  = 0;
    hold_writes  = 0;
    calm         = 1'b0;

    // writes before any tick leave the pins as reset put them
    directed_rows.push_back(make_row(OP_WRITE, 0, 0, 7, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(make_row(OP_WRITE, 31, 15, 7, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(make_row(OP_WRITE, 0, 8, 5, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(make_row(OP_WRITE, 1, 0, 1, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(make_row(OP_WRITE, 1, 8, 2, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(make_row(OP_WRITE, 2, 0, 4, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(make_row(OP_WRITE, 31, 7, 6, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(make_row(OP_WRITE, 31, 8, 3, 1'b1, pins_of(0, 0, 0, 0, 0, 0)));
    // blank tick of row pair 0, then column 0 clock low
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b1, pins_of(0, 0, 0, 0, 1, 0)));
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b1, pins_of(7, 5, 0, 0, 1, 0)));
    // a write in mid scan must not move the scan
    directed_rows.push_back(make_row(OP_WRITE, 0, 0, 0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b0, '0));
    // column 2 comes to its low tick soon: rewrite it just before
    directed_rows.push_back(make_row(OP_WRITE, 2, 8, 7, 1'b0, '0));
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_WRITE, 16, 4, 0, 1'b0, '0));
    directed_rows.push_back(make_row(OP_TICK, 0, 0, 0, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // the block clears its frame store first; the sender just waits on tready
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].col, directed_rows[i].row,
                directed_rows[i].colour, directed_rows[i].typed, directed_rows[i].want);

    // zero hold, with neither side idling
    drain_items();
    set_hold('0);
    calm = 1'b1;
    run_random(120, 65);
    calm = 1'b0;

    drain_items();
    set_hold(HOLD_W'(3));
    run_random(150, 65);

    // longest hold, then lower it while the row is displayed
    drain_items();
    set_hold('1);
    run_random(130, 85);
    drain_items();
    set_hold(HOLD_W'(2));
    run_random(60, 70);

    drain_items();
    set_hold(HOLD_W'($urandom_range(20)));
    run_random(100, 70);

    drain_items();
    repeat (8) @(posedge clk);

    $display("covered %0d scan ticks and %0d pixel writes", ticks_sent, writes_sent);
    $display("hold register written %0d times, reset value through max", hold_writes);
    if (fail_count == 0 && pending_pins.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
